/* hw/rtl/psrpg_pkg.sv */
// Shared types and constants of the position-sensitive pooling gradient scatter.
// Used by psrpg_div and ps_roi_pool_grad_scatter_core; no dependencies.
`timescale 1ns / 1ps

package psrpg_pkg;

   localparam int DIV_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_ROWS      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COLS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_ACCUM  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_START,
      ST_DIV_BX,
      ST_DIV_BW,
      ST_DIV_BY,
      ST_DIV_BH,
      ST_DIV_ADD,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_READ_WAIT,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* hw/rtl/ps_roi_pool_grad_scatter_core.sv */
// Position-sensitive region pooling backward pass: scatters gradients into a plane store.
// Depends on psrpg_pkg and psrpg_div.
`timescale 1ns / 1ps
//
//  channel | ports                        | direction | meaning
//  req     | req_valid / req_stall / req_* | in        | clear, accumulate or read request
//  rsp     | rsp_valid / rsp_stall / rsp_* | out       | cell value of a read request
//  csr     | csr_write / csr_index / csr_data | in     | configuration register write
//
//  A clear request sweeps the whole store, one cell a cycle, through its
//  MAX_BINS_SIDE^2 * MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH cells (65536 by default).
//  An accumulate request runs serial divisions (bin x, bin width, bin y, bin height,
//  per-cell share) in the shared divider, then a read-modify-write of each bin cell
//  on the single memory port. A read request fetches one cell through the same port.
//  Reset runs the same clearing sweep; requests are stalled meanwhile, csr writes are not.
//  The result sits in an output register: the next request is taken while it waits.

module ps_roi_pool_grad_scatter_core #(
   parameter int MAX_WIDTH = 32,
   parameter int MAX_HEIGHT = 32,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_BINS_SIDE = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic signed [15:0] req_box_left,
   input  logic signed [15:0] req_box_top,
   input  logic signed [15:0] req_box_right,
   input  logic signed [15:0] req_box_bottom,
   input  logic [1:0]  req_bin_col,
   input  logic [1:0]  req_bin_row,
   input  logic [1:0]  req_channel,
   input  logic signed [31:0] req_gradient,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_cell_value,
   input  logic        csr_write,
   input  logic [psrpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psrpg_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
   localparam int DEPTH = MAX_BINS_SIDE * MAX_BINS_SIDE * MAX_CHANNELS * PLANE;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);
   localparam int BW = $clog2(MAX_BINS_SIDE + 1);
   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam int DW = psrpg_pkg::DIV_W;

   // configuration registers
   logic [5:0] image_width_ff, image_height_ff;
   logic [2:0] bin_rows_ff, bin_cols_ff, channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= 6'd32;
         image_height_ff <= 6'd32;
         bin_rows_ff <= 3'd3;
         bin_cols_ff <= 3'd3;
         channel_count_ff <= 3'd4;
      end else if (csr_write) begin
         case (csr_index)
            psrpg_pkg::CSR_IMAGE_WIDTH:   image_width_ff <= csr_data;
            psrpg_pkg::CSR_IMAGE_HEIGHT:  image_height_ff <= csr_data;
            psrpg_pkg::CSR_BIN_ROWS:      bin_rows_ff <= csr_data[2:0];
            psrpg_pkg::CSR_BIN_COLS:      bin_cols_ff <= csr_data[2:0];
            psrpg_pkg::CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // effective sizes: clamp registers to [1, MAX]
   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [BW-1:0] nr_eff, nc_eff;
   logic [CW-1:0] nch_eff;

   always_comb begin
      if (image_width_ff == '0) w_eff = XW'(1);
      else if (16'(image_width_ff) > 16'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
      else w_eff = XW'(image_width_ff);
      if (image_height_ff == '0) h_eff = YW'(1);
      else if (16'(image_height_ff) > 16'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
      else h_eff = YW'(image_height_ff);
      if (bin_rows_ff == '0) nr_eff = BW'(1);
      else if (8'(bin_rows_ff) > 8'(MAX_BINS_SIDE)) nr_eff = BW'(MAX_BINS_SIDE);
      else nr_eff = BW'(bin_rows_ff);
      if (bin_cols_ff == '0) nc_eff = BW'(1);
      else if (8'(bin_cols_ff) > 8'(MAX_BINS_SIDE)) nc_eff = BW'(MAX_BINS_SIDE);
      else nc_eff = BW'(bin_cols_ff);
      if (channel_count_ff == '0) nch_eff = CW'(1);
      else if (8'(channel_count_ff) > 8'(MAX_CHANNELS)) nch_eff = CW'(MAX_CHANNELS);
      else nch_eff = CW'(channel_count_ff);
   end

   // latched request
   logic [1:0]         kind_ff;
   logic signed [15:0] left_ff, top_ff, right_ff, bottom_ff;
   logic [1:0]         col_ff, row_ff, ch_ff;
   logic signed [31:0] grad_ff;
   logic [4:0]         cell_x_ff, cell_y_ff;

   // sequencer state
   psrpg_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [XW-1:0]  x0_ff, x0_in, sx_ff, sx_in, bx_ff, bx_in, bw_ff, bw_in, x_ff, x_in;
   logic [YW-1:0]  y0_ff, y0_in, sy_ff, sy_in, by_ff, by_in, bh_ff, bh_in, y_ff, y_in;
   logic [XW:0]    x_end_ff, x_end_in;
   logic [YW:0]    y_end_ff, y_end_in;
   logic signed [31:0] add_ff, add_in;
   logic           rd_zero_ff, rd_zero_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;

   psrpg_pkg::div_req_type div_req;
   psrpg_pkg::div_rsp_type div_rsp;

   psrpg_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // memory
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] mem_rdata_ff;
   logic [AW-1:0]      mem_addr;
   logic               mem_we;
   logic signed [31:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_addr];
   end

   logic               accept;
   logic [31:0]        plane_base;
   logic [AW-1:0]      cell_addr;
   logic [XW-1:0]      x0_c, x1_c;
   logic [YW-1:0]      y0_c, y1_c;
   logic signed [XW+1:0] sx_c;
   logic signed [YW+1:0] sy_c;
   logic               bin_ok;
   logic [31:0]        g_mag;
   logic [DW-1:0]      area;
   logic signed [33:0] sum;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != psrpg_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         left_ff <= req_box_left;
         top_ff <= req_box_top;
         right_ff <= req_box_right;
         bottom_ff <= req_box_bottom;
         col_ff <= req_bin_col;
         row_ff <= req_bin_row;
         ch_ff <= req_channel;
         grad_ff <= req_gradient;
         cell_x_ff <= req_cell_x;
         cell_y_ff <= req_cell_y;
      end
   end

   always_comb begin
      plane_base = ((32'(row_ff) * 32'(MAX_BINS_SIDE) + 32'(col_ff)) * 32'(MAX_CHANNELS)
                    + 32'(ch_ff)) * 32'(PLANE);
      cell_addr = AW'(plane_base + 32'(y_ff) * 32'(MAX_WIDTH) + 32'(x_ff));

      // clamp corners to the image
      if (left_ff < 0) x0_c = '0;
      else if (left_ff > $signed(16'(w_eff - 1'b1))) x0_c = w_eff - 1'b1;
      else x0_c = XW'(left_ff);
      if (right_ff < 0) x1_c = '0;
      else if (right_ff > $signed(16'(w_eff - 1'b1))) x1_c = w_eff - 1'b1;
      else x1_c = XW'(right_ff);
      if (top_ff < 0) y0_c = '0;
      else if (top_ff > $signed(16'(h_eff - 1'b1))) y0_c = h_eff - 1'b1;
      else y0_c = YW'(top_ff);
      if (bottom_ff < 0) y1_c = '0;
      else if (bottom_ff > $signed(16'(h_eff - 1'b1))) y1_c = h_eff - 1'b1;
      else y1_c = YW'(bottom_ff);
      sx_c = $signed({2'b00, x1_c}) - $signed({2'b00, x0_c}) + $signed((XW+2)'(1));
      sy_c = $signed({2'b00, y1_c}) - $signed({2'b00, y0_c}) + $signed((YW+2)'(1));
      bin_ok = (8'(col_ff) < 8'(nc_eff)) && (8'(row_ff) < 8'(nr_eff))
               && (8'(ch_ff) < 8'(nch_eff));

      g_mag = grad_ff[31] ? (~grad_ff + 32'd1) : grad_ff;
      area = DW'(32'(bw_ff) * 32'(div_rsp.quotient));
      sum = 34'(mem_rdata_ff) + 34'(add_ff);
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      x0_in = x0_ff; sx_in = sx_ff; bx_in = bx_ff; bw_in = bw_ff; x_in = x_ff;
      y0_in = y0_ff; sy_in = sy_ff; by_in = by_ff; bh_in = bh_ff; y_in = y_ff;
      x_end_in = x_end_ff;
      y_end_in = y_end_ff;
      add_in = add_ff;
      rd_zero_in = rd_zero_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      div_req.start = 1'b0;
      div_req.dividend = '0;
      div_req.divisor = DW'(1);
      mem_addr = cell_addr;
      mem_we = 1'b0;
      mem_wdata = '0;

      case (state_ff)
         psrpg_pkg::ST_CLEAR: begin
            // sweep the store to zero
            mem_addr = clr_ff;
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) state_in = psrpg_pkg::ST_IDLE;
         end
         psrpg_pkg::ST_IDLE: begin
            if (accept) state_in = psrpg_pkg::ST_SETUP;
         end
         psrpg_pkg::ST_SETUP: begin
            case (kind_ff)
               psrpg_pkg::KIND_CLEAR: begin
                  clr_in = '0;
                  state_in = psrpg_pkg::ST_CLEAR;
               end
               psrpg_pkg::KIND_ACCUM: begin
                  x0_in = x0_c;
                  y0_in = y0_c;
                  sx_in = XW'(sx_c);
                  sy_in = YW'(sy_c);
                  // drop empty boxes and unused bins or channels
                  if (bin_ok && sx_c > 0 && sy_c > 0) state_in = psrpg_pkg::ST_START;
                  else state_in = psrpg_pkg::ST_IDLE;
               end
               psrpg_pkg::KIND_READ: begin
                  x_in = XW'(cell_x_ff);
                  y_in = YW'(cell_y_ff);
                  rd_zero_in = !(bin_ok && 16'(cell_x_ff) < 16'(w_eff)
                                 && 16'(cell_y_ff) < 16'(h_eff));
                  state_in = psrpg_pkg::ST_READ_WAIT;
               end
               default: state_in = psrpg_pkg::ST_IDLE;
            endcase
         end
         psrpg_pkg::ST_START: begin
            div_req.start = 1'b1;
            div_req.dividend = DW'(32'(sx_ff) * 32'(col_ff));
            div_req.divisor = DW'(nc_eff);
            state_in = psrpg_pkg::ST_DIV_BX;
         end
         psrpg_pkg::ST_DIV_BX: begin
            if (div_rsp.done) begin
               bx_in = XW'(32'(x0_ff) + div_rsp.quotient);
               div_req.start = 1'b1;
               div_req.dividend = DW'(32'(sx_ff) + 32'(nc_eff) - 32'd1);
               div_req.divisor = DW'(nc_eff);
               state_in = psrpg_pkg::ST_DIV_BW;
            end
         end
         psrpg_pkg::ST_DIV_BW: begin
            if (div_rsp.done) begin
               bw_in = XW'(div_rsp.quotient);
               div_req.start = 1'b1;
               div_req.dividend = DW'(32'(sy_ff) * 32'(row_ff));
               div_req.divisor = DW'(nr_eff);
               state_in = psrpg_pkg::ST_DIV_BY;
            end
         end
         psrpg_pkg::ST_DIV_BY: begin
            if (div_rsp.done) begin
               by_in = YW'(32'(y0_ff) + div_rsp.quotient);
               div_req.start = 1'b1;
               div_req.dividend = DW'(32'(sy_ff) + 32'(nr_eff) - 32'd1);
               div_req.divisor = DW'(nr_eff);
               state_in = psrpg_pkg::ST_DIV_BH;
            end
         end
         psrpg_pkg::ST_DIV_BH: begin
            if (div_rsp.done) begin
               bh_in = YW'(div_rsp.quotient);
               div_req.start = 1'b1;
               div_req.dividend = g_mag;
               div_req.divisor = area;
               state_in = psrpg_pkg::ST_DIV_ADD;
            end
         end
         psrpg_pkg::ST_DIV_ADD: begin
            if (div_rsp.done) begin
               // quotient rounds toward zero: restore the sign
               add_in = grad_ff[31] ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
               x_in = bx_ff;
               y_in = by_ff;
               x_end_in = ((XW+1)'(bx_ff) + (XW+1)'(bw_ff) < (XW+1)'(w_eff))
                          ? (XW+1)'(bx_ff) + (XW+1)'(bw_ff) : (XW+1)'(w_eff);
               y_end_in = ((YW+1)'(by_ff) + (YW+1)'(bh_ff) < (YW+1)'(h_eff))
                          ? (YW+1)'(by_ff) + (YW+1)'(bh_ff) : (YW+1)'(h_eff);
               state_in = psrpg_pkg::ST_CELL_RD;
            end
         end
         psrpg_pkg::ST_CELL_RD: begin
            state_in = psrpg_pkg::ST_CELL_WR;
         end
         psrpg_pkg::ST_CELL_WR: begin
            // saturate the sum to 32 bits and advance over the bin
            mem_we = 1'b1;
            if (sum > 34'sh07FFFFFFF) mem_wdata = 32'sh7FFFFFFF;
            else if (sum < -34'sh080000000) mem_wdata = 32'sh80000000;
            else mem_wdata = 32'(sum);
            state_in = psrpg_pkg::ST_CELL_RD;
            if ((XW+1)'(x_ff) + 1'b1 < x_end_ff) begin
               x_in = x_ff + 1'b1;
            end else begin
               x_in = bx_ff;
               if ((YW+1)'(y_ff) + 1'b1 < y_end_ff) y_in = y_ff + 1'b1;
               else state_in = psrpg_pkg::ST_IDLE;
            end
         end
         psrpg_pkg::ST_READ_WAIT: begin
            state_in = psrpg_pkg::ST_READ_OUT;
         end
         psrpg_pkg::ST_READ_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_zero_ff ? 32'sd0 : mem_rdata_ff;
               state_in = psrpg_pkg::ST_IDLE;
            end else begin
               mem_addr = cell_addr;
            end
         end
         default: state_in = psrpg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psrpg_pkg::ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff <= x0_in; sx_ff <= sx_in; bx_ff <= bx_in; bw_ff <= bw_in; x_ff <= x_in;
      y0_ff <= y0_in; sy_ff <= sy_in; by_ff <= by_in; bh_ff <= bh_in; y_ff <= y_in;
      x_end_ff <= x_end_in;
      y_end_ff <= y_end_in;
      add_ff <= add_in;
      rd_zero_ff <= rd_zero_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == psrpg_pkg::ST_READ_OUT))
      else $error("response raised outside read completion");
   a_cell_loop: assert property (@(posedge clock) disable iff (reset)
      state_ff == psrpg_pkg::ST_CELL_WR |=>
         (state_ff == psrpg_pkg::ST_CELL_RD || state_ff == psrpg_pkg::ST_IDLE))
      else $error("cell update left its loop");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == psrpg_pkg::ST_DIV_BX || state_ff == psrpg_pkg::ST_DIV_BW
         || state_ff == psrpg_pkg::ST_DIV_BY || state_ff == psrpg_pkg::ST_DIV_BH
         || state_ff == psrpg_pkg::ST_DIV_ADD))
      else $error("divider finished outside a division step");
`endif

endmodule

/* hw/rtl/psrpg_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on psrpg_pkg for the request and response structs.
`timescale 1ns / 1ps

module psrpg_div (
   input  logic                  clock,
   input  logic                  reset,
   input  psrpg_pkg::div_req_type div_req,
   output psrpg_pkg::div_rsp_type div_rsp
);

   localparam int W = psrpg_pkg::DIV_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [W-1:0]     shift_ff, shift_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     divisor_ff, divisor_in;
   logic [W:0]       rem_sh;
   logic [W:0]       rem_sub;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, shift_ff[W-1]};
      ge = rem_sh >= {1'b0, divisor_ff};
      rem_sub = rem_sh - {1'b0, divisor_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         count_in = '0;
         shift_in = div_req.dividend;
         rem_in = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[W-2:0], ge};
         rem_in = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = shift_ff;

endmodule
